FILE: design/rbs_pkg.sv
// Shared types and constants for the record bubble sort block.
// Used by the interfaces, the compare unit and the top level; depends on nothing.
package rbs_pkg;

	localparam int MAX_RECORDS = 32;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

	localparam int NAME_W  = 64;
	localparam int VALUE_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b1;

	// sort key codes
	localparam logic [1:0] KEY_FIRST = 2'd0;
	localparam logic [1:0] KEY_LAST  = 2'd1;
	localparam logic [1:0] KEY_ROLL  = 2'd2;

	typedef struct packed {
		logic [NAME_W-1:0]  first;
		logic [NAME_W-1:0]  last;
		logic [VALUE_W-1:0] roll;
		logic [VALUE_W-1:0] phone;
	} rec_t;

	typedef struct packed {
		logic [1:0] sort_key;
		logic       descending;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD0,
		ST_LD0,
		ST_CMP,
		ST_WB,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

FILE: design/rbs_if.sv
// Valid/ready channel interfaces for record requests and sorted result requests.
// Depends on rbs_pkg for field widths.
interface rbs_in_if;
	logic                       valid;
	logic                       ready;
	logic [rbs_pkg::NAME_W-1:0]  first_name_prefix;
	logic [rbs_pkg::NAME_W-1:0]  last_name_prefix;
	logic [rbs_pkg::VALUE_W-1:0] roll_value;
	logic [rbs_pkg::VALUE_W-1:0] phone_value;
	logic                       last_record;

	modport source (
		output valid, first_name_prefix, last_name_prefix, roll_value, phone_value,
		       last_record,
		input  ready
	);
	modport sink (
		input  valid, first_name_prefix, last_name_prefix, roll_value, phone_value,
		       last_record,
		output ready
	);
endinterface

interface rbs_out_if;
	logic                       valid;
	logic                       ready;
	logic [rbs_pkg::NAME_W-1:0]  out_first_name;
	logic [rbs_pkg::NAME_W-1:0]  out_last_name;
	logic [rbs_pkg::VALUE_W-1:0] out_roll;
	logic [rbs_pkg::VALUE_W-1:0] out_phone;
	logic                       end_of_set;
	logic                       overflowed;

	modport source (
		output valid, out_first_name, out_last_name, out_roll, out_phone, end_of_set,
		       overflowed,
		input  ready
	);
	modport sink (
		input  valid, out_first_name, out_last_name, out_roll, out_phone, end_of_set,
		       overflowed,
		output ready
	);
endinterface

FILE: design/rbs_cmp.sv
// Shared key compare unit: flags when record x must move behind record y.
// Depends on rbs_pkg for rec_t, cfg_t and the key codes.
module rbs_cmp (
	input  rbs_pkg::cfg_t cfg,
	input  rbs_pkg::rec_t x,
	input  rbs_pkg::rec_t y,
	output logic          swap
);

	logic [rbs_pkg::NAME_W-1:0] key_x;
	logic [rbs_pkg::NAME_W-1:0] key_y;
	logic                       key_ok;

	always_comb begin
		key_ok = 1'b1;
		case (cfg.sort_key)
			rbs_pkg::KEY_FIRST: begin
				key_x = x.first;
				key_y = y.first;
			end
			rbs_pkg::KEY_LAST: begin
				key_x = x.last;
				key_y = y.last;
			end
			rbs_pkg::KEY_ROLL: begin
				key_x = rbs_pkg::NAME_W'(x.roll);
				key_y = rbs_pkg::NAME_W'(y.roll);
			end
			default: begin
				// unused key code: never reorder
				key_ok = 1'b0;
				key_x  = '0;
				key_y  = '0;
			end
		endcase
	end

	assign swap = key_ok && (cfg.descending ? (key_x < key_y) : (key_x > key_y));

endmodule

FILE: design/record_bubble_sort_by_key.sv
// Collects records into a 32-entry store, one request per cycle, until a request
// with last_record set arrives; that request closes the set (a record beyond
// capacity is dropped and every result of the set is marked overflowed). The
// block then stops taking requests and bubble-sorts the store in place with one
// key compare unit and the store's single read and single write port: each of the
// n-1 passes carries the record that sorts last (the larger one, or the smaller
// one when descending) up through the store. Results then leave in order, ending
// with end_of_set; input is held off until the last result is registered. A set
// of one record skips the sort. sort_key and descending are read during the sort.
// Depends on rbs_pkg, rbs_in_if/rbs_out_if and rbs_cmp.
module record_bubble_sort_by_key (
	input  logic                          clk,
	input  logic                          arst_n,
	rbs_in_if.sink                        load,
	rbs_out_if.source                     result,
	input  logic                          wr_en,
	input  logic [rbs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rbs_pkg::CFG_DATA_W-1:0] wr_data
);

	localparam int IDX_W = rbs_pkg::IDX_W;
	localparam int CNT_W = rbs_pkg::CNT_W;

	rbs_pkg::state_t state_q, state_d;

	rbs_pkg::cfg_t    cfg_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] passes_q;
	logic [CNT_W-1:0] emit_idx_q;
	rbs_pkg::rec_t    carry_q;

	rbs_pkg::rec_t    store_mem [rbs_pkg::MAX_RECORDS];
	rbs_pkg::rec_t    rdata_q;

	logic             out_valid_q;
	rbs_pkg::rec_t    out_rec_q;
	logic             out_eos_q;
	logic             out_ovf_q;

	// combinational control
	logic             accept;
	logic             stored;
	logic [CNT_W-1:0] set_size;
	logic [CNT_W-1:0] last_pos;
	logic [CNT_W-1:0] idx_m1;
	logic [CNT_W-1:0] idx_p1;
	logic             scan_done;
	logic             emit_last;
	logic             out_free;
	logic             out_load;
	logic             swap;
	logic             we;
	logic [IDX_W-1:0] waddr;
	rbs_pkg::rec_t    wdata;
	logic [IDX_W-1:0] raddr;
	rbs_pkg::rec_t    in_rec;

	assign in_rec.first = load.first_name_prefix;
	assign in_rec.last  = load.last_name_prefix;
	assign in_rec.roll  = load.roll_value;
	assign in_rec.phone = load.phone_value;

	assign accept    = load.valid && load.ready;
	assign stored    = count_q < CNT_W'(rbs_pkg::MAX_RECORDS);
	assign set_size  = stored ? (count_q + CNT_W'(1)) : count_q;
	assign last_pos  = count_q - CNT_W'(1);
	assign idx_m1    = idx_q - CNT_W'(1);
	assign idx_p1    = idx_q + CNT_W'(1);
	assign scan_done = idx_q == last_pos;
	assign emit_last = emit_idx_q == last_pos;
	assign out_free  = !out_valid_q || result.ready;

	rbs_cmp u_cmp (
		.cfg  (cfg_q),
		.x    (carry_q),
		.y    (rdata_q),
		.swap (swap)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbs_pkg::ST_LOAD: begin
				if (accept && load.last_record) begin
					state_d = (set_size > CNT_W'(1)) ? rbs_pkg::ST_RD0 : rbs_pkg::ST_EMIT_RD;
				end
			end
			rbs_pkg::ST_RD0:     state_d = rbs_pkg::ST_LD0;
			rbs_pkg::ST_LD0:     state_d = rbs_pkg::ST_CMP;
			rbs_pkg::ST_CMP: begin
				if (scan_done) begin
					state_d = rbs_pkg::ST_WB;
				end
			end
			rbs_pkg::ST_WB: begin
				state_d = (passes_q == CNT_W'(1)) ? rbs_pkg::ST_EMIT_RD : rbs_pkg::ST_RD0;
			end
			rbs_pkg::ST_EMIT_RD: state_d = rbs_pkg::ST_EMIT_LD;
			rbs_pkg::ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_last ? rbs_pkg::ST_LOAD : rbs_pkg::ST_EMIT_RD;
				end
			end
			default:             state_d = rbs_pkg::ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		load.ready = 1'b0;
		we         = 1'b0;
		waddr      = '0;
		wdata      = carry_q;
		raddr      = '0;
		out_load   = 1'b0;
		case (state_q)
			rbs_pkg::ST_LOAD: begin
				load.ready = 1'b1;
				we         = load.valid && stored;
				waddr      = count_q[IDX_W-1:0];
				wdata      = in_rec;
			end
			rbs_pkg::ST_RD0: begin
				raddr = '0;
			end
			rbs_pkg::ST_LD0: begin
				raddr = IDX_W'(1);
			end
			rbs_pkg::ST_CMP: begin
				// the record that sorts first drops into the slot behind the carried one
				we    = 1'b1;
				waddr = idx_m1[IDX_W-1:0];
				wdata = swap ? rdata_q : carry_q;
				raddr = idx_p1[IDX_W-1:0];
			end
			rbs_pkg::ST_WB: begin
				we    = 1'b1;
				waddr = last_pos[IDX_W-1:0];
				wdata = carry_q;
			end
			rbs_pkg::ST_EMIT_RD: begin
				raddr = emit_idx_q[IDX_W-1:0];
			end
			rbs_pkg::ST_EMIT_LD: begin
				raddr    = emit_idx_q[IDX_W-1:0];
				out_load = out_free;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// record store
	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		rdata_q <= store_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbs_pkg::ST_LOAD;
			cfg_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			passes_q    <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (wr_en) begin
				case (wr_index)
					rbs_pkg::REG_SORT_KEY:   cfg_q.sort_key   <= wr_data[1:0];
					rbs_pkg::REG_DESCENDING: cfg_q.descending <= wr_data[0];
					default: ;
				endcase
			end

			case (state_q)
				rbs_pkg::ST_LOAD: begin
					if (accept) begin
						if (stored) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						passes_q   <= set_size - CNT_W'(1);
						emit_idx_q <= '0;
					end
				end
				rbs_pkg::ST_LD0: begin
					idx_q <= CNT_W'(1);
				end
				rbs_pkg::ST_CMP: begin
					idx_q <= idx_p1;
				end
				rbs_pkg::ST_WB: begin
					passes_q <= passes_q - CNT_W'(1);
				end
				rbs_pkg::ST_EMIT_LD: begin
					if (out_free) begin
						emit_idx_q <= emit_idx_q + CNT_W'(1);
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == rbs_pkg::ST_LD0) begin
			carry_q <= rdata_q;
		end else if (state_q == rbs_pkg::ST_CMP && !swap) begin
			carry_q <= rdata_q;
		end
		if (out_load) begin
			out_rec_q <= rdata_q;
			out_eos_q <= emit_last;
			out_ovf_q <= ovf_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.out_first_name = out_rec_q.first;
	assign result.out_last_name  = out_rec_q.last;
	assign result.out_roll       = out_rec_q.roll;
	assign result.out_phone      = out_rec_q.phone;
	assign result.end_of_set     = out_eos_q;
	assign result.overflowed     = out_ovf_q;

`ifndef SYNTHESIS
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(rbs_pkg::MAX_RECORDS))
		else $error("record count beyond store capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbs_pkg::ST_CMP |-> idx_q != '0 && idx_q < count_q)
		else $error("sort scan index outside the stored set");

	a_stall_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && load.last_record |=> !load.ready)
		else $error("request taken right after the closing record");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> emit_idx_q < count_q)
		else $error("result emitted beyond the stored set");
`endif

endmodule
